@@ src/hsb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSB to RGB converter package
// Beat types, arithmetic constants and pipeline control shared by the
// converter and its per-channel scaling unit.
// ----------------------------------------------------------------------------
package hsb_pkg;

    // Input beat: hue in degrees, saturation and brightness in percent.
    typedef struct packed {
        logic [8:0] hue_deg;
        logic [6:0] sat_pct;
        logic [6:0] bright_pct;
    } hsb_in_t;

    // Output beat: one byte per color channel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } hsb_out_t;

    // Stage enables for the channel scaling stages.
    typedef struct packed {
        logic en3;
        logic en4;
        logic en5;
        logic en6;
    } hsb_stage_ctl_t;

    // Hue sectors of 120 degrees each.
    typedef enum logic [1:0] {
        SECTOR_0 = 2'd0,
        SECTOR_1 = 2'd1,
        SECTOR_2 = 2'd2
    } hsb_sector_t;

    // Input limits and sector geometry.
    localparam logic [8:0]  HUE_LIMIT    = 9'd360;
    localparam logic [6:0]  PCT_LIMIT    = 7'd100;
    localparam logic [8:0]  SECTOR_SPAN  = 9'd120;
    localparam logic [13:0] F_FULL       = 14'd12000;

    // Full scale of one output channel.
    localparam logic [15:0] CHANNEL_MAX  = 16'd255;

    // Widths of the scaling path.
    localparam int BF_W   = 21;   // bright * F, at most 1200000
    localparam int PROD_W = 37;   // bright * F * CHANNEL_MAX
    localparam int LOW_W  = 29;   // products below the saturation limit
    localparam int RCP_W  = 28;   // reciprocal multiplier
    localparam int RCP_SH = 48;   // reciprocal scaling shift

    // Divisor, saturation threshold and its reciprocal.
    localparam logic [BF_W-1:0]   F_DIVISOR = BF_W'(1200000);
    localparam logic [PROD_W-1:0] SAT_LIMIT = PROD_W'(256 * 1200000);
    localparam logic [RCP_W-1:0]  RCP_MULT  = RCP_W'((64'd1 << RCP_SH) / 64'd1200000);

endpackage
`default_nettype wire

@@ src/hsb_chan.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSB channel scaling unit
// Four-stage pipeline computing floor(bright * CHANNEL_MAX * F / 1200000),
// saturated to 255, with the division done by a reciprocal multiply and a
// single correction step.
// ----------------------------------------------------------------------------
module hsb_chan (
    input  wire logic                    aclk,
    input  wire hsb_pkg::hsb_stage_ctl_t ctl,
    input  wire logic [6:0]              bright_in,
    input  wire logic [13:0]             f_in,
    output logic [7:0]                   chan_out
);

    logic [hsb_pkg::BF_W-1:0]        bf_reg, bf_next;
    logic [hsb_pkg::PROD_W-1:0]      prod_next;
    logic [hsb_pkg::LOW_W-1:0]       plow4_reg, plow4_next;
    logic                            sat4_reg, sat4_next;
    logic [hsb_pkg::LOW_W-1:0]       plow5_reg;
    logic                            sat5_reg;
    logic [hsb_pkg::LOW_W+hsb_pkg::RCP_W-1:0] rcp_prod;
    logic [7:0]                      qe_reg, qe_next;
    logic [hsb_pkg::LOW_W-1:0]       qd;
    logic [hsb_pkg::LOW_W-1:0]       rem;
    logic [7:0]                      q_reg, q_next;

    // Stage 3: brightness times the sector factor.
    assign bf_next = hsb_pkg::BF_W'(bright_in) * hsb_pkg::BF_W'(f_in);

    // Stage 4: scale to channel range and flag products that saturate.
    always_comb begin
        prod_next  = hsb_pkg::PROD_W'(bf_reg) * hsb_pkg::PROD_W'(hsb_pkg::CHANNEL_MAX);
        sat4_next  = (prod_next >= hsb_pkg::SAT_LIMIT);
        plow4_next = prod_next[hsb_pkg::LOW_W-1:0];
    end

    // Stage 5: quotient estimate, low by at most one.
    always_comb begin
        rcp_prod = (hsb_pkg::LOW_W+hsb_pkg::RCP_W)'(plow4_reg)
                 * (hsb_pkg::LOW_W+hsb_pkg::RCP_W)'(hsb_pkg::RCP_MULT);
        qe_next  = rcp_prod[hsb_pkg::RCP_SH+7:hsb_pkg::RCP_SH];
    end

    // Stage 6: correct the estimate from the remainder and saturate.
    always_comb begin
        qd  = hsb_pkg::LOW_W'(qe_reg) * hsb_pkg::LOW_W'(hsb_pkg::F_DIVISOR);
        rem = plow5_reg - qd;
        if (sat5_reg) begin
            q_next = 8'hFF;
        end else if (rem >= hsb_pkg::LOW_W'(hsb_pkg::F_DIVISOR)) begin
            q_next = qe_reg + 8'd1;
        end else begin
            q_next = qe_reg;
        end
    end

    // Payload registers, each held while its stage is stalled.
    always_ff @(posedge aclk) begin
        if (ctl.en3) begin
            bf_reg <= bf_next;
        end
        if (ctl.en4) begin
            plow4_reg <= plow4_next;
            sat4_reg  <= sat4_next;
        end
        if (ctl.en5) begin
            qe_reg    <= qe_next;
            plow5_reg <= plow4_reg;
            sat5_reg  <= sat4_reg;
        end
        if (ctl.en6) begin
            q_reg <= q_next;
        end
    end

    assign chan_out = q_reg;

endmodule
`default_nettype wire

@@ src/hsb_to_rgb_converter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSB to RGB converter
// Converts hue, saturation and brightness to an RGB byte triple using the
// three-sector scheme, in a six-stage pipeline.
//
//  Channel | Ports                        | Beat
//  --------+------------------------------+------------------------------------
//  input   | s_valid, s_ready, s_data     | hue_deg, sat_pct, bright_pct
//  output  | m_valid, m_ready, m_data     | red, green, blue
//
// One beat is accepted per cycle while s_ready is high. Stage 1 clamps and
// finds the sector, stage 2 forms the three sector factors, stages 3 to 6
// scale and divide each channel.
// Reset clears the stage valid bits only. A stall on the output holds the
// last stage, and earlier stages keep filling any empty slots before it.
// ----------------------------------------------------------------------------
module hsb_to_rgb_converter (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire hsb_pkg::hsb_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output hsb_pkg::hsb_out_t     m_data
);

    // Stage valid bits and enables.
    logic [6:1] v_reg, v_next;
    logic [6:1] en;
    hsb_pkg::hsb_stage_ctl_t ctl;

    // Stage 1 signals.
    logic [8:0]  hue_c;
    logic [6:0]  sat_c, bright_c;
    hsb_pkg::hsb_sector_t sector_next;
    logic [8:0]  x_full;
    logic [6:0]  x1;
    logic [13:0] xs_next, ts_next;
    logic [13:0] xs_reg, ts_reg;
    logic [6:0]  bright1_reg;
    hsb_pkg::hsb_sector_t sector1_reg;

    // Stage 2 signals.
    logic [13:0] fp_next, fs_next, ft_next;
    logic [13:0] fp_reg, fs_reg, ft_reg;
    logic [6:0]  bright2_reg;
    hsb_pkg::hsb_sector_t sector2_reg, sector3_reg, sector4_reg;
    hsb_pkg::hsb_sector_t sector5_reg, sector6_reg;

    // Channel results by role.
    logic [7:0] q_prim, q_sec, q_tert;

    // Ready chain: a stage advances when it is empty or the next one advances.
    always_comb begin
        en[6] = !v_reg[6] || m_ready;
        en[5] = !v_reg[5] || en[6];
        en[4] = !v_reg[4] || en[5];
        en[3] = !v_reg[3] || en[4];
        en[2] = !v_reg[2] || en[3];
        en[1] = !v_reg[1] || en[2];
        ctl.en3 = en[3];
        ctl.en4 = en[4];
        ctl.en5 = en[5];
        ctl.en6 = en[6];
    end

    assign s_ready = en[1];
    assign m_valid = v_reg[6];

    // Valid bits move with their beats.
    always_comb begin
        v_next = v_reg;
        if (en[1]) begin
            v_next[1] = s_valid;
        end
        if (en[2]) begin
            v_next[2] = v_reg[1];
        end
        if (en[3]) begin
            v_next[3] = v_reg[2];
        end
        if (en[4]) begin
            v_next[4] = v_reg[3];
        end
        if (en[5]) begin
            v_next[5] = v_reg[4];
        end
        if (en[6]) begin
            v_next[6] = v_reg[5];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    // Stage 1: clamp inputs, pick the sector and form the hue products.
    always_comb begin
        hue_c    = (s_data.hue_deg > hsb_pkg::HUE_LIMIT) ? hsb_pkg::HUE_LIMIT
                                                         : s_data.hue_deg;
        sat_c    = (s_data.sat_pct > hsb_pkg::PCT_LIMIT) ? hsb_pkg::PCT_LIMIT
                                                         : s_data.sat_pct;
        bright_c = (s_data.bright_pct > hsb_pkg::PCT_LIMIT) ? hsb_pkg::PCT_LIMIT
                                                            : s_data.bright_pct;
        if (hue_c < hsb_pkg::SECTOR_SPAN) begin
            sector_next = hsb_pkg::SECTOR_0;
            x_full      = hue_c;
        end else if (hue_c < (hsb_pkg::SECTOR_SPAN << 1)) begin
            sector_next = hsb_pkg::SECTOR_1;
            x_full      = hue_c - hsb_pkg::SECTOR_SPAN;
        end else begin
            sector_next = hsb_pkg::SECTOR_2;
            x_full      = hue_c - (hsb_pkg::SECTOR_SPAN << 1);
        end
        x1      = x_full[6:0];
        xs_next = 14'(x1) * 14'(sat_c);
        ts_next = 14'(hsb_pkg::SECTOR_SPAN) * 14'(sat_c);
    end

    // Stage 2: primary, secondary and tertiary factors.
    always_comb begin
        fp_next = hsb_pkg::F_FULL - xs_reg;
        fs_next = hsb_pkg::F_FULL - ts_reg + xs_reg;
        ft_next = hsb_pkg::F_FULL - ts_reg;
    end

    // Payload registers of the first two stages and the sector tag.
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            xs_reg      <= xs_next;
            ts_reg      <= ts_next;
            bright1_reg <= bright_c;
            sector1_reg <= sector_next;
        end
        if (en[2]) begin
            fp_reg      <= fp_next;
            fs_reg      <= fs_next;
            ft_reg      <= ft_next;
            bright2_reg <= bright1_reg;
            sector2_reg <= sector1_reg;
        end
        if (en[3]) begin
            sector3_reg <= sector2_reg;
        end
        if (en[4]) begin
            sector4_reg <= sector3_reg;
        end
        if (en[5]) begin
            sector5_reg <= sector4_reg;
        end
        if (en[6]) begin
            sector6_reg <= sector5_reg;
        end
    end

    // Channel scaling, one unit per role.
    hsb_chan u_chan_prim (
        .aclk      (aclk),
        .ctl       (ctl),
        .bright_in (bright2_reg),
        .f_in      (fp_reg),
        .chan_out  (q_prim)
    );

    hsb_chan u_chan_sec (
        .aclk      (aclk),
        .ctl       (ctl),
        .bright_in (bright2_reg),
        .f_in      (fs_reg),
        .chan_out  (q_sec)
    );

    hsb_chan u_chan_tert (
        .aclk      (aclk),
        .ctl       (ctl),
        .bright_in (bright2_reg),
        .f_in      (ft_reg),
        .chan_out  (q_tert)
    );

    // Route the roles to red, green and blue by sector.
    always_comb begin
        case (sector6_reg)
            hsb_pkg::SECTOR_0: begin
                m_data.red   = q_prim;
                m_data.green = q_sec;
                m_data.blue  = q_tert;
            end
            hsb_pkg::SECTOR_1: begin
                m_data.red   = q_tert;
                m_data.green = q_prim;
                m_data.blue  = q_sec;
            end
            default: begin
                m_data.red   = q_sec;
                m_data.green = q_tert;
                m_data.blue  = q_prim;
            end
        endcase
    end

endmodule
`default_nettype wire
